>>> src/ppcr_pkg.sv
// Shared package for the particle pair collision resolver.
// Holds widths, register map codes, outcome codes, the beat type and the pipeline
// payload types; no dependencies.
`default_nettype none
package ppcr_pkg;

  localparam int FRAC_BITS = 8;
  localparam int POS_BITS  = 18;
  localparam int VEL_BITS  = 14;
  localparam int RAD_BITS  = 14;
  localparam int LIM_BITS  = 13;
  localparam int BNC_BITS  = 9;
  localparam int THR_BITS  = 14;

  // Divider widths: numerator magnitude, divisor and quotient bits kept
  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 46;
  localparam int DIV_Q_W   = 24;

  // Register byte addresses
  localparam logic [3:0] ADDR_LIMIT  = 4'd0;
  localparam logic [3:0] ADDR_BOUNCE = 4'd4;
  localparam logic [3:0] ADDR_THRESH = 4'd8;

  // Outcome codes
  localparam logic [1:0] OUT_NONE    = 2'd0;
  localparam logic [1:0] OUT_CONTACT = 2'd1;
  localparam logic [1:0] OUT_REPEL   = 2'd2;
  localparam logic [1:0] OUT_IMPULSE = 2'd3;

  // One input beat
  typedef struct packed {
    logic [POS_BITS-1:0]        ax;
    logic [POS_BITS-1:0]        ay;
    logic signed [VEL_BITS-1:0] avx;
    logic signed [VEL_BITS-1:0] avy;
    logic [RAD_BITS-1:0]        ar;
    logic [POS_BITS-1:0]        bx;
    logic [POS_BITS-1:0]        by;
    logic signed [VEL_BITS-1:0] bvx;
    logic signed [VEL_BITS-1:0] bvy;
    logic [RAD_BITS-1:0]        br;
  } pair_t;

  // Configuration values seen by the datapath
  typedef struct packed {
    logic [LIM_BITS-1:0] limit;
    logic [BNC_BITS-1:0] bounce;
    logic [THR_BITS-1:0] thresh;
  } cfg_t;

  // Geometry carried alongside the square root
  typedef struct packed {
    pair_t              p;
    logic signed [18:0] dx;
    logic signed [18:0] dy;
    logic [14:0]        rs;
    logic [37:0]        d2;
    logic               touch;
    logic signed [34:0] num;
  } geo_t;

  // Decision carried alongside the dividers
  typedef struct packed {
    pair_t      p;
    logic [1:0] oc;
    logic       chg;
  } ctl_t;

endpackage
`default_nettype wire

>>> src/ppcr_regs.sv
// APB-style configuration registers for the collision resolver.
// Depends on ppcr_pkg.
`default_nettype none
module ppcr_regs (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output ppcr_pkg::cfg_t   cfg
);

  logic [ppcr_pkg::LIM_BITS-1:0] limit_r;
  logic [ppcr_pkg::BNC_BITS-1:0] bounce_r;
  logic [ppcr_pkg::THR_BITS-1:0] thresh_r;
  logic                          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= 13'd3840;
      bounce_r <= 9'd205;
      thresh_r <= 14'd512;
    end else if (wr_en) begin
      unique case (paddr)
        ppcr_pkg::ADDR_LIMIT:  limit_r  <= pwdata[ppcr_pkg::LIM_BITS-1:0];
        ppcr_pkg::ADDR_BOUNCE: bounce_r <= pwdata[ppcr_pkg::BNC_BITS-1:0];
        ppcr_pkg::ADDR_THRESH: thresh_r <= pwdata[ppcr_pkg::THR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (paddr)
      ppcr_pkg::ADDR_LIMIT:  prdata = {19'd0, limit_r};
      ppcr_pkg::ADDR_BOUNCE: prdata = {23'd0, bounce_r};
      ppcr_pkg::ADDR_THRESH: prdata = {18'd0, thresh_r};
      default:               prdata = 32'd0;
    endcase
  end

  assign cfg = '{limit: limit_r, bounce: bounce_r, thresh: thresh_r};

endmodule
`default_nettype wire

>>> src/ppcr_isqrt.sv
// Pipelined integer square root, one result bit per stage over 19 stages.
// Depends on ppcr_pkg for the geometry carried alongside the radicand.
`default_nettype none
module ppcr_isqrt (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_vld,
  input  wire logic [37:0]    in_val,
  input  wire ppcr_pkg::geo_t in_tag,
  output logic                out_vld,
  output logic [18:0]         out_root,
  output ppcr_pkg::geo_t      out_tag
);

  // One result bit per stage; 19 stages for a 38-bit radicand.
  localparam int STG = 19;

  logic [STG-1:0]  vld_r;
  logic [37:0]     rem_r  [STG];
  logic [18:0]     root_r [STG];
  logic [37:0]     val_r  [STG];
  ppcr_pkg::geo_t  tag_r  [STG];

  logic [37:0]     x_rem   [STG];
  logic [18:0]     x_root  [STG];
  logic [37:0]     x_val   [STG];
  ppcr_pkg::geo_t  x_tag   [STG];
  logic [37:0]     rem_nx  [STG];
  logic [18:0]     root_nx [STG];
  logic [39:0]     rem_cat;
  logic [39:0]     trial;

  // Restoring square root: bring down two bits, try 4*root+1.
  always_comb begin
    x_rem[0]  = 38'd0;
    x_root[0] = 19'd0;
    x_val[0]  = in_val;
    x_tag[0]  = in_tag;
    for (int s = 1; s < STG; s++) begin
      x_rem[s]  = rem_r[s-1];
      x_root[s] = root_r[s-1];
      x_val[s]  = val_r[s-1];
      x_tag[s]  = tag_r[s-1];
    end
    rem_cat = 40'd0;
    trial   = 40'd0;
    for (int s = 0; s < STG; s++) begin
      rem_cat = {x_rem[s], x_val[s][37:36]};
      trial   = {19'd0, x_root[s], 2'b01};
      if (rem_cat >= trial) begin
        rem_nx[s]  = 38'(rem_cat - trial);
        root_nx[s] = {x_root[s][17:0], 1'b1};
      end else begin
        rem_nx[s]  = rem_cat[37:0];
        root_nx[s] = {x_root[s][17:0], 1'b0};
      end
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= {vld_r[STG-2:0], in_vld};
  end

  // Stage registers
  always_ff @(posedge clk) begin
    for (int s = 0; s < STG; s++) begin
      rem_r[s]  <= rem_nx[s];
      root_r[s] <= root_nx[s];
      val_r[s]  <= {x_val[s][35:0], 2'b00};
      tag_r[s]  <= x_tag[s];
    end
  end

  assign out_vld  = vld_r[STG-1];
  assign out_root = root_r[STG-1];
  assign out_tag  = tag_r[STG-1];

endmodule
`default_nettype wire

>>> src/ppcr_divr.sv
// Pipelined signed divide with round-half-away, one quotient bit per stage.
// Depends on ppcr_pkg for widths and the decision carried alongside; divisor
// must be nonzero when valid.
`default_nettype none
module ppcr_divr (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_vld,
  input  wire logic                              in_neg,
  input  wire logic [ppcr_pkg::DIV_NUM_W-1:0]    in_mag,
  input  wire logic [ppcr_pkg::DIV_DEN_W-1:0]    in_den,
  input  wire ppcr_pkg::ctl_t                    in_tag,
  output logic                                   out_vld,
  output logic signed [ppcr_pkg::DIV_Q_W:0]      out_q,
  output ppcr_pkg::ctl_t                         out_tag
);

  // Quotient bits produced; any quotient above them sets a sticky flag.
  localparam int STG = ppcr_pkg::DIV_Q_W;
  localparam int N_W = ppcr_pkg::DIV_NUM_W + 1;
  localparam int D_W = ppcr_pkg::DIV_DEN_W;
  localparam int W_W = N_W + D_W;

  logic [STG-1:0]  vld_r;
  logic [N_W-1:0]  num_r [STG];
  logic [D_W-1:0]  den_r [STG];
  logic [STG-1:0]  q_r   [STG];
  logic [STG-1:0]  big_r;
  logic [STG-1:0]  neg_r;
  ppcr_pkg::ctl_t  tag_r [STG];

  logic [N_W-1:0]  x_num  [STG];
  logic [D_W-1:0]  x_den  [STG];
  logic [STG-1:0]  x_q    [STG];
  logic [STG-1:0]  x_big;
  logic [STG-1:0]  x_neg;
  ppcr_pkg::ctl_t  x_tag  [STG];
  logic [N_W-1:0]  num_nx [STG];
  logic [STG-1:0]  take;
  logic [N_W-1:0]  biased;
  logic [W_W-1:0]  lim;
  logic [W_W-1:0]  dsh;

  // Add half the divisor at entry; any quotient bit above the kept ones sets big.
  always_comb begin
    biased   = {1'b0, in_mag} + N_W'(in_den >> 1);
    lim      = {{N_W{1'b0}}, in_den} << STG;
    x_num[0] = biased;
    x_den[0] = in_den;
    x_q[0]   = '0;
    x_big[0] = (W_W'(biased) >= lim);
    x_neg[0] = in_neg;
    x_tag[0] = in_tag;
    for (int s = 1; s < STG; s++) begin
      x_num[s] = num_r[s-1];
      x_den[s] = den_r[s-1];
      x_q[s]   = q_r[s-1];
      x_big[s] = big_r[s-1];
      x_neg[s] = neg_r[s-1];
      x_tag[s] = tag_r[s-1];
    end
    dsh = '0;
    for (int s = 0; s < STG; s++) begin
      dsh       = {{N_W{1'b0}}, x_den[s]} << (STG - 1 - s);
      take[s]   = (W_W'(x_num[s]) >= dsh);
      num_nx[s] = take[s] ? N_W'(W_W'(x_num[s]) - dsh) : x_num[s];
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= {vld_r[STG-2:0], in_vld};
  end

  // Stage registers
  always_ff @(posedge clk) begin
    for (int s = 0; s < STG; s++) begin
      num_r[s] <= num_nx[s];
      den_r[s] <= x_den[s];
      q_r[s]   <= {x_q[s][STG-2:0], take[s]};
      big_r[s] <= x_big[s];
      neg_r[s] <= x_neg[s];
      tag_r[s] <= x_tag[s];
    end
  end

  // A huge quotient is clipped; it only feeds a saturator downstream.
  logic [STG-1:0] qm;
  always_comb begin
    qm    = big_r[STG-1] ? {STG{1'b1}} : q_r[STG-1];
    out_q = neg_r[STG-1] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
  end
  assign out_vld = vld_r[STG-1];
  assign out_tag = tag_r[STG-1];

endmodule
`default_nettype wire

>>> src/particle_pair_collision_resolver.sv
// Top level of the particle pair collision resolver: front-end geometry,
// pipelined square root, pipelined dividers and the saturating back end.
// Depends on ppcr_pkg, ppcr_regs, ppcr_isqrt and ppcr_divr.
// Throughput one pair per cycle. The depth is three front-end stages, the
// 19-stage square root, two decision stages, the two 24-stage dividers in
// parallel and the output register; busy is always low.
// Reset is synchronous and active low; it clears the valid bits and restores
// the register defaults. The receiver cannot stall.
`default_nettype none
module particle_pair_collision_resolver (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [17:0] in_a_pos_x,
  input  wire logic [17:0] in_a_pos_y,
  input  wire logic [13:0] in_a_vel_x,
  input  wire logic [13:0] in_a_vel_y,
  input  wire logic [13:0] in_a_radius,
  input  wire logic [17:0] in_b_pos_x,
  input  wire logic [17:0] in_b_pos_y,
  input  wire logic [13:0] in_b_vel_x,
  input  wire logic [13:0] in_b_vel_y,
  input  wire logic [13:0] in_b_radius,
  output logic             out_valid,
  output logic [13:0]      out_a_new_vel_x,
  output logic [13:0]      out_a_new_vel_y,
  output logic [13:0]      out_b_new_vel_x,
  output logic [13:0]      out_b_new_vel_y,
  output logic [1:0]       out_outcome,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  ppcr_pkg::cfg_t cfg;

  ppcr_regs u_regs (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg
  );

  assign busy = 1'b0;

  // Stage 1: differences and radius sum
  logic               s1_vld_r;
  ppcr_pkg::pair_t    s1_p_r;
  logic signed [18:0] s1_dx_r, s1_dy_r;
  logic [14:0]        s1_rs_r;
  logic signed [14:0] s1_rvx_r, s1_rvy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= start;
  end
  always_ff @(posedge clk) begin
    s1_p_r   <= '{ax: in_a_pos_x, ay: in_a_pos_y, avx: in_a_vel_x, avy: in_a_vel_y,
                 ar: in_a_radius, bx: in_b_pos_x, by: in_b_pos_y, bvx: in_b_vel_x,
                 bvy: in_b_vel_y, br: in_b_radius};
    s1_dx_r  <= $signed({1'b0, in_a_pos_x}) - $signed({1'b0, in_b_pos_x});
    s1_dy_r  <= $signed({1'b0, in_a_pos_y}) - $signed({1'b0, in_b_pos_y});
    s1_rs_r  <= 15'(in_a_radius) + 15'(in_b_radius);
    s1_rvx_r <= 15'($signed(in_b_vel_x)) - 15'($signed(in_a_vel_x));
    s1_rvy_r <= 15'($signed(in_b_vel_y)) - 15'($signed(in_a_vel_y));
  end

  // Stage 2: squares and products
  logic               s2_vld_r;
  ppcr_pkg::pair_t    s2_p_r;
  logic signed [18:0] s2_dx_r, s2_dy_r;
  logic [14:0]        s2_rs_r;
  logic [36:0]        s2_dxx_r, s2_dyy_r;
  logic [29:0]        s2_rr_r;
  logic signed [33:0] s2_nx_r, s2_ny_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else        s2_vld_r <= s1_vld_r;
  end
  always_ff @(posedge clk) begin
    s2_p_r   <= s1_p_r;
    s2_dx_r  <= s1_dx_r;
    s2_dy_r  <= s1_dy_r;
    s2_rs_r  <= s1_rs_r;
    s2_dxx_r <= 37'(s1_dx_r * s1_dx_r);
    s2_dyy_r <= 37'(s1_dy_r * s1_dy_r);
    s2_rr_r  <= s1_rs_r * s1_rs_r;
    s2_nx_r  <= 34'(s1_rvx_r * s1_dx_r);
    s2_ny_r  <= 34'(s1_rvy_r * s1_dy_r);
  end

  // Stage 3: distance squared, contact test, normal speed
  logic           s3_vld_r;
  ppcr_pkg::geo_t s3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else        s3_vld_r <= s2_vld_r;
  end
  always_ff @(posedge clk) begin
    s3_r.p     <= s2_p_r;
    s3_r.dx    <= s2_dx_r;
    s3_r.dy    <= s2_dy_r;
    s3_r.rs    <= s2_rs_r;
    s3_r.d2    <= 38'(s2_dxx_r) + 38'(s2_dyy_r);
    s3_r.touch <= (38'(s2_dxx_r) + 38'(s2_dyy_r)) <= 38'(s2_rr_r);
    s3_r.num   <= 35'(s2_nx_r) + 35'(s2_ny_r);
  end

  // Square root with the geometry carried alongside
  logic           sq_vld;
  logic [18:0]    sq_root;
  ppcr_pkg::geo_t sq_g;
  ppcr_isqrt u_isqrt (
    .clk, .rst_n, .in_vld(s3_vld_r), .in_val(s3_r.d2), .in_tag(s3_r),
    .out_vld(sq_vld), .out_root(sq_root), .out_tag(sq_g)
  );

  // Stage 4: overlap, decision, numerators and denominators
  logic               s4_vld_r;
  ppcr_pkg::ctl_t     s4_c_r;
  logic [15:0]        s4_ov_r;
  logic [21:0]        s4_d5_r;
  logic signed [18:0] s4_dx_r, s4_dy_r;
  logic signed [44:0] s4_sc_r;
  logic [45:0]        s4_d2s_r;
  logic               rep, imp;
  logic [15:0]        ov;

  always_comb begin
    ov  = 16'(sq_g.rs) - 16'(sq_root);
    rep = sq_g.touch && (sq_g.d2 != 38'd0) && (ov > 16'(cfg.thresh));
    imp = sq_g.touch && (sq_g.d2 != 38'd0) && (sq_g.num > 35'sd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s4_vld_r <= 1'b0;
    else        s4_vld_r <= sq_vld;
  end
  always_ff @(posedge clk) begin
    s4_c_r.p   <= sq_g.p;
    s4_c_r.chg <= rep | imp;
    if (!sq_g.touch)  s4_c_r.oc <= ppcr_pkg::OUT_NONE;
    else if (imp)     s4_c_r.oc <= ppcr_pkg::OUT_IMPULSE;
    else if (rep)     s4_c_r.oc <= ppcr_pkg::OUT_REPEL;
    else              s4_c_r.oc <= ppcr_pkg::OUT_CONTACT;
    s4_ov_r  <= ov;
    s4_d5_r  <= 22'(sq_root) * 22'd5;
    s4_dx_r  <= sq_g.dx;
    s4_dy_r  <= sq_g.dy;
    s4_sc_r  <= 45'(sq_g.num * $signed({1'b0, cfg.bounce}));
    s4_d2s_r <= {sq_g.d2, 8'd0};
  end

  // Stage 5: full numerators, choosing repulsion or impulse
  logic               s5_vld_r;
  ppcr_pkg::ctl_t     s5_c_r;
  logic [63:0]        s5_mx_r, s5_my_r;
  logic               s5_nx_r, s5_ny_r;
  logic [45:0]        s5_den_r;
  logic signed [64:0] px, py;

  always_comb begin
    if (s4_c_r.oc == ppcr_pkg::OUT_IMPULSE) begin
      px = 65'(s4_dx_r * s4_sc_r);
      py = 65'(s4_dy_r * s4_sc_r);
    end else begin
      px = 65'(s4_dx_r * $signed({1'b0, s4_ov_r}));
      py = 65'(s4_dy_r * $signed({1'b0, s4_ov_r}));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s5_vld_r <= 1'b0;
    else        s5_vld_r <= s4_vld_r;
  end
  always_ff @(posedge clk) begin
    s5_c_r   <= s4_c_r;
    s5_nx_r  <= px[64];
    s5_ny_r  <= py[64];
    s5_mx_r  <= 64'(px[64] ? -px : px);
    s5_my_r  <= 64'(py[64] ? -py : py);
    s5_den_r <= (s4_c_r.oc == ppcr_pkg::OUT_IMPULSE) ? s4_d2s_r :
                (s4_c_r.chg ? 46'(s4_d5_r) : 46'd1);
  end

  // Rounded divisions, x and y in parallel
  logic               dvx_vld, dvy_vld;
  logic signed [24:0] qx, qy;
  ppcr_pkg::ctl_t     dv_c, dv_cy;
  ppcr_divr u_divx (
    .clk, .rst_n, .in_vld(s5_vld_r), .in_neg(s5_nx_r), .in_mag(s5_mx_r),
    .in_den(s5_den_r), .in_tag(s5_c_r), .out_vld(dvx_vld), .out_q(qx), .out_tag(dv_c)
  );
  ppcr_divr u_divy (
    .clk, .rst_n, .in_vld(s5_vld_r), .in_neg(s5_ny_r), .in_mag(s5_my_r),
    .in_den(s5_den_r), .in_tag(s5_c_r), .out_vld(dvy_vld), .out_q(qy), .out_tag(dv_cy)
  );

  // Final stage: add, saturate and register the result beat
  function automatic logic [13:0] sat(input logic signed [26:0] v,
                                      input logic [12:0] lim);
    logic signed [26:0] l;
    begin
      l = $signed({14'd0, lim});
      if (v >= l)       sat = 14'(l);
      else if (v <= -l) sat = 14'(-l);
      else              sat = 14'(v);
    end
  endfunction

  logic signed [26:0] sax, say, sbx, sby;
  always_comb begin
    sax = 27'($signed(dv_c.p.avx)) + 27'(qx);
    say = 27'($signed(dv_c.p.avy)) + 27'(qy);
    sbx = 27'($signed(dv_c.p.bvx)) - 27'(qx);
    sby = 27'($signed(dv_c.p.bvy)) - 27'(qy);
  end

  logic out_valid_r;
  logic [13:0] oax_r, oay_r, obx_r, oby_r;
  logic [1:0]  ooc_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= dvx_vld;
  end
  always_ff @(posedge clk) begin
    ooc_r <= dv_c.oc;
    if (dv_c.chg) begin
      oax_r <= sat(sax, cfg.limit);
      oay_r <= sat(say, cfg.limit);
      obx_r <= sat(sbx, cfg.limit);
      oby_r <= sat(sby, cfg.limit);
    end else begin
      oax_r <= dv_c.p.avx;
      oay_r <= dv_c.p.avy;
      obx_r <= dv_c.p.bvx;
      oby_r <= dv_c.p.bvy;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_a_new_vel_x = oax_r;
  assign out_a_new_vel_y = oay_r;
  assign out_b_new_vel_x = obx_r;
  assign out_b_new_vel_y = oby_r;
  assign out_outcome     = ooc_r;

  // The two divider lanes run in lock step.
  a_lanes: assert property (@(posedge clk) disable iff (!rst_n) dvx_vld == dvy_vld)
    else $error("divider lanes out of step");
  a_tag: assert property (@(posedge clk) disable iff (!rst_n)
    dvx_vld |-> dv_c.oc == dv_cy.oc) else $error("divider tags differ");
  a_nochg: assert property (@(posedge clk) disable iff (!rst_n)
    dvx_vld && (dv_c.oc == ppcr_pkg::OUT_NONE || dv_c.oc == ppcr_pkg::OUT_CONTACT)
    |-> !dv_c.chg) else $error("unchanged outcome marked as change");
  a_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(dvx_vld)) else $error("result beat without data");

endmodule
`default_nettype wire
